// File: sv/kdh_pkg.sv
package kdh_pkg;

  localparam int TIME_W       = 32;
  localparam int LEVEL_W      = 7;
  localparam int DEBOUNCE_W   = 16;
  localparam int CODE_W       = 8;
  localparam int CODES_KEYS   = 7;
  localparam int KEY_CODES_W  = CODES_KEYS * CODE_W;
  localparam int REPORT_SLOTS = 6;
  localparam int REPORT_W     = REPORT_SLOTS * CODE_W;
  localparam int IN_DATA_W    = ((TIME_W + LEVEL_W + 7) / 8) * 8;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [DEBOUNCE_W-1:0]  DEBOUNCE_RESET  = 16'd100;
  localparam logic [KEY_CODES_W-1:0] KEY_CODES_RESET = 56'h0A15284F505152;

  // register indexes on the configuration port
  localparam logic CFG_DEBOUNCE  = 1'b0;
  localparam logic CFG_KEY_CODES = 1'b1;

  typedef enum logic {
    FR_IDLE,
    FR_SCAN
  } front_state_t;

  // one classified key event; a word with last set closes the poll
  typedef struct packed {
    logic              act;
    logic              press;
    logic [CODE_W-1:0] code;
    logic              last;
  } key_event_t;

endpackage

// File: sv/kdh_front.sv
module kdh_front import kdh_pkg::*; #(
  parameter int NUM_KEYS = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   poll_valid,
  output logic                   poll_ready,
  input  logic [TIME_W-1:0]      poll_now,
  input  logic [LEVEL_W-1:0]     poll_levels,
  input  logic [DEBOUNCE_W-1:0]  debounce_ms,
  input  logic [KEY_CODES_W-1:0] key_codes,
  output logic                   ev_push,
  output key_event_t             ev_data,
  input  logic                   ev_full
);

  localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  front_state_t        state, state_next;
  logic [TIME_W-1:0]   now_ms;
  logic [LEVEL_W-1:0]  levels;
  logic [KW-1:0]       key_idx;
  logic [NUM_KEYS-1:0] pressed;
  logic [TIME_W-1:0]   lockout [NUM_KEYS];

  logic [TIME_W-1:0]   diff;
  logic [2:0]          key3;
  logic [7:0]          lv8;
  logic [63:0]         codes64;
  logic                is_pressed;
  logic                changed;
  logic                last_key;
  logic                step;

  always_comb begin
    key3       = 3'(key_idx);
    lv8        = {1'b0, levels};        // keys above the level field read as pressed
    codes64    = {8'h00, key_codes};    // keys above the code register have code 0
    diff       = now_ms - lockout[key_idx];
    is_pressed = !lv8[key3];
    changed    = !diff[TIME_W-1] && (is_pressed != pressed[key_idx]);
    last_key   = (key_idx == KW'(NUM_KEYS - 1));
    step       = (state == FR_SCAN) && !ev_full;
  end

  always_comb begin
    state_next = state;
    poll_ready = 1'b0;
    unique case (state)
      FR_IDLE: begin
        poll_ready = 1'b1;
        if (poll_valid) state_next = FR_SCAN;
      end
      FR_SCAN: begin
        if (step && last_key) state_next = FR_IDLE;
      end
      default: state_next = FR_IDLE;
    endcase
  end

  assign ev_push       = step && (changed || last_key);
  assign ev_data.act   = changed;
  assign ev_data.press = is_pressed;
  assign ev_data.code  = codes64[key3*8 +: 8];
  assign ev_data.last  = last_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= FR_IDLE;
      key_idx <= '0;
      pressed <= '0;
      for (int k = 0; k < NUM_KEYS; k++) lockout[k] <= '0;
    end else begin
      state <= state_next;
      if (state == FR_IDLE && poll_valid) begin
        key_idx <= '0;
      end else if (step) begin
        if (changed) begin
          pressed[key_idx] <= is_pressed;
          lockout[key_idx] <= now_ms + TIME_W'(debounce_ms);
        end
        if (!last_key) key_idx <= key_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == FR_IDLE && poll_valid) begin
      now_ms <= poll_now;
      levels <= poll_levels;
    end
  end

endmodule

// File: sv/kdh_fifo.sv
module kdh_fifo import kdh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  key_event_t din,
  output logic       full,
  input  logic       pop,
  output key_event_t dout,
  output logic       empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  key_event_t    mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
      unique case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr] <= din;
  end

endmodule

// File: sv/kdh_back.sv
module kdh_back import kdh_pkg::*; #(
  parameter int NUM_SLOTS = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  key_event_t          ev_data,
  input  logic                ev_empty,
  output logic                ev_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [REPORT_W-1:0] out_report,
  output logic                out_last
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [CODE_W-1:0]   slots [NUM_SLOTS];
  logic                hold_valid;
  logic                hold_final;
  logic [REPORT_W-1:0] hold_report;

  logic                out_free;
  logic                flush;
  logic                found;
  logic                done;
  logic [SW-1:0]       hit_idx;
  logic                changed;
  logic [CODE_W-1:0]   new_val;
  logic [REPORT_W-1:0] new_report;

  assign out_free = !out_valid || out_ready;
  assign flush    = hold_valid && hold_final && out_free;
  assign ev_pop   = !flush && !ev_empty && out_free;

  // press: first slot holding the code or empty; release: first slot holding the code
  always_comb begin
    found   = 1'b0;
    done    = 1'b0;
    hit_idx = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (!done) begin
        if (slots[s] == ev_data.code) begin
          done = 1'b1;
          if (!ev_data.press) begin
            found   = 1'b1;
            hit_idx = SW'(s);
          end
        end else if (ev_data.press && slots[s] == '0) begin
          done    = 1'b1;
          found   = 1'b1;
          hit_idx = SW'(s);
        end
      end
    end
    changed = ev_data.act && found;
    new_val = ev_data.press ? ev_data.code : '0;
  end

  always_comb begin
    new_report = '0;
    for (int s = 0; s < NUM_SLOTS && s < REPORT_SLOTS; s++) begin
      new_report[s*CODE_W +: CODE_W] = (SW'(s) == hit_idx) ? new_val : slots[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SLOTS; s++) slots[s] <= '0;
      hold_valid <= 1'b0;
      hold_final <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (flush || (ev_pop && changed && hold_valid)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (flush) begin
        hold_valid <= 1'b0;
        hold_final <= 1'b0;
      end else if (ev_pop) begin
        if (changed) begin
          slots[hit_idx] <= new_val;
          hold_valid <= 1'b1;
          hold_final <= ev_data.last;
        end else if (ev_data.last && hold_valid) begin
          hold_final <= 1'b1;
        end
      end
    end
  end

  // the newest report waits in the hold register until it is known whether it closes the poll
  always_ff @(posedge clk) begin
    if (flush) begin
      out_report <= hold_report;
      out_last   <= 1'b1;
    end else if (ev_pop && changed) begin
      hold_report <= new_report;
      if (hold_valid) begin
        out_report <= hold_report;
        out_last   <= 1'b0;
      end
    end
  end

endmodule

// File: sv/key_debounce_hid_report_unit.sv
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata: now_ms[31:0], key_levels[38:32]
// m_*       out  m_tvalid/m_tready  m_tdata: slot_a..slot_f, tlast = last_of_poll
// cfg_*     in   cfg_wr_en          cfg_index 0 debounce_ms, 1 key_codes
//
// The key scanner checks one key per cycle while the event queue is not full,
// and the next poll is taken once the scan of the last key has been queued.
// A report is held after its slot update until the next slot change or the
// poll's last key shows whether it closes the poll.
// Reset (rst, synchronous) releases all keys, clears lockouts and slots.
// A full event queue stalls the scanner; a stalled output stalls the slot updater.
module key_debounce_hid_report_unit import kdh_pkg::*; #(
  parameter int NUM_KEYS  = 7,
  parameter int NUM_SLOTS = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,   // now_ms, key_levels, zero pad
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [REPORT_W-1:0]    m_tdata,   // slot_a, slot_b, slot_c, slot_d, slot_e, slot_f
  output logic                   m_tlast,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_index,
  input  logic [KEY_CODES_W-1:0] cfg_data
);

  logic [DEBOUNCE_W-1:0]  debounce_ms;
  logic [KEY_CODES_W-1:0] key_codes;

  logic       ev_push;
  logic       ev_full;
  logic       ev_pop;
  logic       ev_empty;
  key_event_t ev_in;
  key_event_t ev_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
      key_codes   <= KEY_CODES_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:  debounce_ms <= cfg_data[DEBOUNCE_W-1:0];
        CFG_KEY_CODES: key_codes   <= cfg_data;
        default:       ;
      endcase
    end
  end

  kdh_front #(.NUM_KEYS(NUM_KEYS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .poll_valid  (s_tvalid),
    .poll_ready  (s_tready),
    .poll_now    (s_tdata[TIME_W-1:0]),
    .poll_levels (s_tdata[TIME_W +: LEVEL_W]),
    .debounce_ms (debounce_ms),
    .key_codes   (key_codes),
    .ev_push     (ev_push),
    .ev_data     (ev_in),
    .ev_full     (ev_full)
  );

  kdh_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (ev_push),
    .din   (ev_in),
    .full  (ev_full),
    .pop   (ev_pop),
    .dout  (ev_out),
    .empty (ev_empty)
  );

  kdh_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .ev_data    (ev_out),
    .ev_empty   (ev_empty),
    .ev_pop     (ev_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_report (m_tdata),
    .out_last   (m_tlast)
  );

endmodule
